>>> hw/rtl/whs_pkg.sv
`default_nettype none
package whs_pkg;

   localparam int MAX_WAYPOINTS = 64;
   localparam int CORDIC_STEPS  = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int STEER_MAX     = 16384;
   localparam int CORDIC_W      = 36;
   localparam int ANGLE_W       = 24;

   localparam logic [7:0] CSR_GAIN   = 8'd0;
   localparam logic [7:0] CSR_RADIUS = 8'd1;
   localparam logic [7:0] CSR_GPS    = 8'd2;
   localparam logic [7:0] CSR_COUNT  = 8'd3;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [5:0]         wp_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [15:0] yaw_angle;
   } whs_req_type;

   typedef struct packed {
      logic signed [15:0] steering;
      logic signed [15:0] heading_error;
      logic signed [15:0] bearing;
      logic [5:0]         target_index;
      logic               all_within;
   } whs_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HEAD, ST_RSQ, ST_R2, ST_RD, ST_DIFF, ST_MX, ST_MY,
      ST_CMP, ST_BEAR, ST_BWAIT, ST_STEER, ST_CLAMP
   } whs_state_type;

   // atan(2^-i) in 2^-24 turn units
   function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] i);
      logic [ANGLE_W-1:0] r;
      unique case (i)
         5'd0:    r = 24'd2097152;
         5'd1:    r = 24'd1238021;
         5'd2:    r = 24'd654136;
         5'd3:    r = 24'd332050;
         5'd4:    r = 24'd166669;
         5'd5:    r = 24'd83416;
         5'd6:    r = 24'd41718;
         5'd7:    r = 24'd20860;
         5'd8:    r = 24'd10430;
         5'd9:    r = 24'd5215;
         5'd10:   r = 24'd2608;
         5'd11:   r = 24'd1304;
         5'd12:   r = 24'd652;
         5'd13:   r = 24'd326;
         5'd14:   r = 24'd163;
         5'd15:   r = 24'd81;
         5'd16:   r = 24'd41;
         5'd17:   r = 24'd20;
         5'd18:   r = 24'd10;
         5'd19:   r = 24'd5;
         5'd20:   r = 24'd3;
         5'd21:   r = 24'd1;
         5'd22:   r = 24'd1;
         default: r = 24'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/waypoint_heading_steering_top.sv
`default_nettype none
// load request: result valid the cycle after acceptance
// position update: heading CORDIC (yaw heading skips it), radius square, per waypoint
// read, diff, squares, compare (one more read, diff if all inside); bearing, steer, clamp
// one request at a time; the next is taken at the earliest in the cycle its result is taken
// synchronous active-high reset: pointer, previous position and registers to defaults
// waypoint table is not cleared by reset
module waypoint_heading_steering_top #(
   parameter int MaxWaypoints = whs_pkg::MAX_WAYPOINTS,
   parameter int CordicSteps  = whs_pkg::CORDIC_STEPS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire whs_pkg::whs_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output whs_pkg::whs_rsp_type      rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [7:0]           csr_index,
   input  wire logic [15:0]          csr_data
);

   localparam int AW = $clog2(MaxWaypoints);
   localparam int CW = $clog2(MaxWaypoints + 1);

   whs_pkg::whs_state_type state_ff, state_in;
   whs_pkg::whs_rsp_type   rsp_ff;

   logic               rsp_valid_ff;
   logic [15:0]        gain_ff, radius_ff;
   logic               gps_ff;
   logic [6:0]         count_cfg_ff;
   logic [AW-1:0]      ptr_ff, ptr_next, wr_addr;
   logic [CW-1:0]      count_ff, iter_ff, count_eff;
   logic               final_ff, all_ff, far_ff;
   logic signed [31:0] prev_x_ff, prev_y_ff, vx_ff, vy_ff, wx, wy;
   logic [15:0]        heading_ff, err_ff, adx_ff, ady_ff;
   logic [31:0]        r2_ff, sq_ff;
   logic signed [32:0] ddx_ff, ddy_ff, ddx, ddy, adx, ady, cx0, cy0;
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] prod_ff, prod, sh;
   logic [32:0]        dsum;
   logic               accept, in_radius, cstart, cdone, wr_en;
   logic [15:0]        cangle;
   logic [63:0]        rd_data;
   logic signed [15:0] steer;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == whs_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (count_cfg_ff == 7'd0) begin
         count_eff = CW'(1);
      end else if (32'(count_cfg_ff) > MaxWaypoints) begin
         count_eff = CW'(MaxWaypoints);
      end else begin
         count_eff = CW'(count_cfg_ff);
      end
   end

   assign ptr_next = (32'(ptr_ff) + 1 >= 32'(count_ff)) ? '0 : ptr_ff + 1'b1;

   assign wx   = rd_data[63:32];
   assign wy   = rd_data[31:0];
   assign ddx  = 33'(wx) - 33'(vx_ff);
   assign ddy  = 33'(wy) - 33'(vy_ff);
   assign adx  = ddx[32] ? -ddx : ddx;
   assign ady  = ddy[32] ? -ddy : ddy;
   assign dsum = {1'b0, sq_ff} + {1'b0, prod_ff[31:0]};
   assign in_radius = !far_ff && (dsum < {1'b0, r2_ff});

   // shared multiplier
   always_comb begin
      case (state_ff)
         whs_pkg::ST_RSQ: begin
            mul_a = {1'b0, radius_ff};
            mul_b = {1'b0, radius_ff};
         end
         whs_pkg::ST_MX: begin
            mul_a = {1'b0, adx_ff};
            mul_b = {1'b0, adx_ff};
         end
         whs_pkg::ST_MY: begin
            mul_a = {1'b0, ady_ff};
            mul_b = {1'b0, ady_ff};
         end
         whs_pkg::ST_STEER: begin
            mul_a = {err_ff[15], err_ff};
            mul_b = {1'b0, gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign sh = prod_ff >>> 9;
   always_comb begin
      if (sh > 34'sd16384) begin
         steer = 16'(whs_pkg::STEER_MAX);
      end else if (sh < -34'sd16384) begin
         steer = -16'(whs_pkg::STEER_MAX);
      end else begin
         steer = 16'(sh);
      end
   end

   assign cstart = (accept && req_data.req_type == whs_pkg::REQ_UPDATE && gps_ff)
                   || (state_ff == whs_pkg::ST_BEAR);
   assign cx0 = (state_ff == whs_pkg::ST_IDLE) ? 33'(req_data.coord_x) - 33'(prev_x_ff) : ddx_ff;
   assign cy0 = (state_ff == whs_pkg::ST_IDLE) ? 33'(req_data.coord_y) - 33'(prev_y_ff) : ddy_ff;

   assign wr_en   = accept && req_data.req_type == whs_pkg::REQ_LOAD
                    && 32'(req_data.wp_index) < MaxWaypoints;
   assign wr_addr = AW'(req_data.wp_index);

   whs_cordic #(.CordicSteps(CordicSteps)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cstart),
      .x0    (cx0),
      .y0    (cy0),
      .done  (cdone),
      .angle (cangle)
   );

   whs_wp_ram #(.Depth(MaxWaypoints)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.coord_x, req_data.coord_y}),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         whs_pkg::ST_IDLE: begin
            if (accept && req_data.req_type == whs_pkg::REQ_UPDATE) begin
               state_in = gps_ff ? whs_pkg::ST_HEAD : whs_pkg::ST_RSQ;
            end
         end
         whs_pkg::ST_HEAD:  if (cdone) state_in = whs_pkg::ST_RSQ;
         whs_pkg::ST_RSQ:   state_in = whs_pkg::ST_R2;
         whs_pkg::ST_R2:    state_in = whs_pkg::ST_RD;
         whs_pkg::ST_RD:    state_in = whs_pkg::ST_DIFF;
         whs_pkg::ST_DIFF:  state_in = final_ff ? whs_pkg::ST_BEAR : whs_pkg::ST_MX;
         whs_pkg::ST_MX:    state_in = whs_pkg::ST_MY;
         whs_pkg::ST_MY:    state_in = whs_pkg::ST_CMP;
         whs_pkg::ST_CMP:   state_in = in_radius ? whs_pkg::ST_RD : whs_pkg::ST_BEAR;
         whs_pkg::ST_BEAR:  state_in = whs_pkg::ST_BWAIT;
         whs_pkg::ST_BWAIT: if (cdone) state_in = whs_pkg::ST_STEER;
         whs_pkg::ST_STEER: state_in = whs_pkg::ST_CLAMP;
         whs_pkg::ST_CLAMP: state_in = whs_pkg::ST_IDLE;
         default:           state_in = whs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= whs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= 16'd1608;
         radius_ff    <= 16'd384;
         gps_ff       <= 1'b1;
         count_cfg_ff <= 7'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            whs_pkg::CSR_GAIN:   gain_ff      <= csr_data;
            whs_pkg::CSR_RADIUS: radius_ff    <= csr_data;
            whs_pkg::CSR_GPS:    gps_ff       <= csr_data[0];
            whs_pkg::CSR_COUNT:  count_cfg_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((accept && req_data.req_type == whs_pkg::REQ_LOAD)
             || state_ff == whs_pkg::ST_CLAMP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_data.req_type == whs_pkg::REQ_UPDATE) begin
            prev_x_ff <= req_data.coord_x;
            prev_y_ff <= req_data.coord_y;
            if (32'(ptr_ff) >= 32'(count_eff)) begin
               ptr_ff <= '0;
            end
         end
         if (state_ff == whs_pkg::ST_CMP && in_radius) begin
            ptr_ff <= ptr_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod;
      if (accept && req_data.req_type == whs_pkg::REQ_LOAD) begin
         rsp_ff.steering      <= '0;
         rsp_ff.heading_error <= '0;
         rsp_ff.bearing       <= '0;
         rsp_ff.target_index  <= 6'(ptr_ff);
         rsp_ff.all_within    <= 1'b0;
      end else if (accept) begin
         vx_ff      <= req_data.coord_x;
         vy_ff      <= req_data.coord_y;
         heading_ff <= req_data.yaw_angle;
         count_ff   <= count_eff;
         iter_ff    <= '0;
         final_ff   <= 1'b0;
         all_ff     <= 1'b0;
      end
      unique case (state_ff)
         whs_pkg::ST_HEAD: if (cdone) heading_ff <= cangle;
         whs_pkg::ST_R2:   r2_ff <= prod_ff[31:0];
         whs_pkg::ST_DIFF: begin
            ddx_ff <= ddx;
            ddy_ff <= ddy;
            adx_ff <= adx[15:0];
            ady_ff <= ady[15:0];
            far_ff <= (adx[32:16] != '0) || (ady[32:16] != '0);
         end
         whs_pkg::ST_MY:   sq_ff <= prod_ff[31:0];
         whs_pkg::ST_CMP: begin
            if (in_radius) begin
               iter_ff <= iter_ff + 1'b1;
               if (32'(iter_ff) + 1 == 32'(count_ff)) begin
                  all_ff   <= 1'b1;
                  final_ff <= 1'b1;
               end
            end
         end
         whs_pkg::ST_BWAIT: begin
            if (cdone) begin
               rsp_ff.bearing <= cangle;
               err_ff         <= cangle - heading_ff;
            end
         end
         whs_pkg::ST_CLAMP: begin
            rsp_ff.steering      <= steer;
            rsp_ff.heading_error <= err_ff;
            rsp_ff.target_index  <= 6'(ptr_ff);
            rsp_ff.all_within    <= all_ff;
         end
         default: ;
      endcase
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != whs_pkg::ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");

   a_cordic_done_expected: assert property (@(posedge clock) disable iff (reset)
      cdone |-> (state_ff == whs_pkg::ST_HEAD || state_ff == whs_pkg::ST_BWAIT))
      else $error("cordic finished outside a wait state");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == whs_pkg::ST_CMP) |-> (32'(ptr_ff) < 32'(count_ff)))
      else $error("target pointer beyond ring");

   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.steering <= 16'sd16384 && rsp_ff.steering >= -16'sd16384))
      else $error("steering out of range");

   a_clamp_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == whs_pkg::ST_CLAMP) |-> !rsp_valid_ff)
      else $error("result overwritten before taken");

endmodule
`default_nettype wire

>>> hw/rtl/whs_wp_ram.sv
`default_nettype none
module whs_wp_ram #(
   parameter int Depth = whs_pkg::MAX_WAYPOINTS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [63:0]              wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [63:0]                   rd_data
);

   logic [63:0] mem [Depth];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/whs_cordic.sv
`default_nettype none
module whs_cordic #(
   parameter int CordicSteps = whs_pkg::CORDIC_STEPS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [32:0] x0,
   input  wire logic signed [32:0] y0,
   output logic                    done,
   output logic [15:0]             angle
);

   localparam int SW = $clog2(CordicSteps);
   localparam int W  = whs_pkg::CORDIC_W;
   localparam int ZW = whs_pkg::ANGLE_W;

   logic signed [W-1:0] x_ff, y_ff, xe, ye, xs, ys;
   logic [ZW-1:0]       z_ff, zr;
   logic [SW-1:0]       step_ff;
   logic                busy_ff, done_ff, zero_ff;

   assign xe = W'(x0);
   assign ye = W'(y0);
   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == SW'(CordicSteps - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= '0;
         zero_ff <= (x0 == '0) && (y0 == '0);
         if (xe[W-1] && !ye[W-1]) begin
            x_ff <= ye;
            y_ff <= -xe;
            z_ff <= ZW'(1 << 22);
         end else if (xe[W-1]) begin
            x_ff <= -ye;
            y_ff <= xe;
            z_ff <= ZW'(0) - ZW'(1 << 22);
         end else begin
            x_ff <= xe;
            y_ff <= ye;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (!y_ff[W-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + whs_pkg::atan_turn(5'(step_ff));
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - whs_pkg::atan_turn(5'(step_ff));
         end
      end
   end

   assign zr    = z_ff + ZW'(128);
   assign done  = done_ff;
   assign angle = zero_ff ? 16'd0 : zr[ZW-1:8];

endmodule
`default_nettype wire

>>> dv/waypoint_heading_steering_top_tb.sv
`default_nettype none
module waypoint_heading_steering_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_ITEMS = 48;

   typedef struct packed {
      whs_pkg::whs_req_type req;
      logic                 known;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   whs_pkg::whs_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   whs_pkg::whs_rsp_type rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [7:0]           csr_index;
   logic [15:0]          csr_data;

   waypoint_heading_steering_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // steering model state
   logic signed [31:0] wp_x [whs_pkg::MAX_WAYPOINTS];
   logic signed [31:0] wp_y [whs_pkg::MAX_WAYPOINTS];
   int unsigned        target_slot;
   logic signed [31:0] last_x, last_y;
   logic [15:0]        gain_reg, radius_reg;
   logic               gps_reg;
   logic [6:0]         count_reg;

   whs_pkg::whs_rsp_type expected_steering_q [$];
   int          mismatches = 0;
   bit          no_idle = 0;
   bit          hold_pending = 0;

   logic [23:0] atan_lut [24] = '{
      24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
      24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304, 24'd652,
      24'd326, 24'd163, 24'd81, 24'd41, 24'd20, 24'd10, 24'd5, 24'd3, 24'd1,
      24'd1, 24'd0
   };

   stim_row_type directed_rows [19] = '{
      '{'{whs_pkg::REQ_LOAD,   6'd0,  32'sd256000,   32'sd128000,   16'sd0},    1'b1},
      '{'{whs_pkg::REQ_LOAD,   6'd63, 32'sh7FFFFFFF, 32'sh80000000, 16'sd0},    1'b1},
      '{'{whs_pkg::REQ_LOAD,   6'd1,  32'sh80000000, 32'sh7FFFFFFF, 16'sd0},    1'b1},
      '{'{whs_pkg::REQ_LOAD,   6'd2,  32'sd0,        32'sd0,        16'sd0},    1'b1},
      '{'{whs_pkg::REQ_LOAD,   6'd3,  -32'sd5000,    -32'sd7000,    16'sd0},    1'b1},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd0,        32'sd0,        16'sd0},    1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd0,        32'sd0,        16'sd0},    1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd256000,   32'sd128000,   16'sd0},    1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF}, 1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sh80000000, 32'sh80000000, 16'sh8000}, 1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  -32'sd256000,  32'sd0,        16'sh8000}, 1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd256384,   32'sd128000,   16'sd0},    1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd256383,   32'sd128000,   16'sd0},    1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd256000,   32'sd127617,   16'sd0},    1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd300000,   32'sd200000,   16'sd0},    1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd100000,   -32'sd400000,  16'sd0},    1'b0},
      '{'{whs_pkg::REQ_LOAD,   6'd0,  32'sd0,        32'sd1000,     16'sd0},    1'b1},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd0,        32'sd0,        16'sd0},    1'b0},
      '{'{whs_pkg::REQ_UPDATE, 6'd0,  32'sd0,        -32'sd3000,    16'sd0},    1'b0}
   };

   function automatic logic [15:0] atan2_angle(input longint x, input longint y);
      logic [23:0] z;
      logic [23:0] rounded;
      longint      t, xs, ys;
      if (x == 0 && y == 0) return 16'd0;
      z = 24'd0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 24'h400000;
         end else begin
            t = x; x = -y; y = t; z = 24'hC00000;
         end
      end
      for (int i = 0; i < whs_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + atan_lut[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_lut[i];
         end
      end
      rounded = z + 24'd128;
      return rounded[23:8];
   endfunction

   function automatic bit inside_radius(input longint vx, input longint vy,
                                        input int unsigned slot);
      longint dx, dy, r;
      dx = longint'(wp_x[slot]) - vx;
      dy = longint'(wp_y[slot]) - vy;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      r = longint'(radius_reg);
      if (dx >= 65536 || dy >= 65536) return 1'b0;
      return (dx * dx + dy * dy) < (r * r);
   endfunction

   function automatic int unsigned ring_size();
      if (count_reg == 0) return 1;
      if (count_reg > whs_pkg::MAX_WAYPOINTS) return whs_pkg::MAX_WAYPOINTS;
      return 32'(count_reg);
   endfunction

   function automatic whs_pkg::whs_rsp_type predict_steering(input whs_pkg::whs_req_type r);
      whs_pkg::whs_rsp_type o;
      longint               vx, vy, prod, steer;
      logic [15:0]          heading, bear, err;
      int unsigned          n, i;
      o = '0;
      if (r.req_type == whs_pkg::REQ_LOAD) begin
         wp_x[r.wp_index] = r.coord_x;
         wp_y[r.wp_index] = r.coord_y;
         o.target_index = target_slot[5:0];
         return o;
      end
      vx = longint'(r.coord_x);
      vy = longint'(r.coord_y);
      n = ring_size();
      if (gps_reg)
         heading = atan2_angle(vx - longint'(last_x), vy - longint'(last_y));
      else
         heading = r.yaw_angle;
      last_x = r.coord_x;
      last_y = r.coord_y;
      if (target_slot >= n) target_slot = 0;
      for (i = 0; i < n; i++) begin
         if (!inside_radius(vx, vy, target_slot)) break;
         target_slot = (target_slot + 1 >= n) ? 0 : target_slot + 1;
      end
      bear = atan2_angle(longint'(wp_x[target_slot]) - vx,
                         longint'(wp_y[target_slot]) - vy);
      err = bear - heading;
      prod = longint'($signed(err)) * longint'(gain_reg);
      steer = prod >>> 9;
      if (steer > whs_pkg::STEER_MAX) steer = whs_pkg::STEER_MAX;
      if (steer < -whs_pkg::STEER_MAX) steer = -whs_pkg::STEER_MAX;
      o.steering = steer[15:0];
      o.heading_error = err;
      o.bearing = bear;
      o.target_index = target_slot[5:0];
      o.all_within = (i == n);
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_request(input whs_pkg::whs_req_type r, input bit known);
      whs_pkg::whs_rsp_type e;
      while (!no_idle && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      e = predict_steering(r);
      if (known) e = '0;
      expected_steering_q = {expected_steering_q, e};
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         whs_pkg::CSR_GAIN:   gain_reg = value;
         whs_pkg::CSR_RADIUS: radius_reg = value;
         whs_pkg::CSR_GPS:    gps_reg = value[0];
         whs_pkg::CSR_COUNT:  count_reg = value[6:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_steering_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [31:0] near_coord(input logic signed [31:0] c);
      int unsigned r;
      r = 32'(radius_reg);
      return c + $signed(32'($urandom_range(0, r))) - $signed(32'(r / 2));
   endfunction

   function automatic logic signed [31:0] cluster_coord();
      return $signed(32'($urandom_range(0, 8191))) - 32'sd4096;
   endfunction

   function automatic whs_pkg::whs_req_type random_request();
      whs_pkg::whs_req_type r;
      int unsigned pick, s;
      r.yaw_angle = 16'($urandom);
      r.wp_index = 6'($urandom);
      pick = $urandom_range(99);
      if (pick < 12) begin
         r.req_type = whs_pkg::REQ_LOAD;
         r.coord_x = ($urandom_range(3) == 0) ? $urandom : cluster_coord();
         r.coord_y = ($urandom_range(3) == 0) ? $urandom : cluster_coord();
      end else begin
         r.req_type = whs_pkg::REQ_UPDATE;
         s = (target_slot < ring_size()) ? target_slot : 0;
         if (pick < 70) begin
            r.coord_x = near_coord(wp_x[s]);
            r.coord_y = near_coord(wp_y[s]);
         end else if (pick < 88) begin
            r.coord_x = cluster_coord();
            r.coord_y = cluster_coord();
         end else begin
            r.coord_x = $urandom;
            r.coord_y = $urandom;
         end
      end
      return r;
   endfunction

   // response side: checks and backpressure
   initial begin
      int hold_left;
      whs_pkg::whs_rsp_type e;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_steering_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               mismatches++;
            end else begin
               e = expected_steering_q[0];
               expected_steering_q.delete(0);
               if (rsp_data.steering !== e.steering) begin
                  $display("%0t: steering expected %0d actual %0d",
                           $time, e.steering, rsp_data.steering);
                  mismatches++;
               end
               if (rsp_data.heading_error !== e.heading_error) begin
                  $display("%0t: heading_error expected %0d actual %0d",
                           $time, e.heading_error, rsp_data.heading_error);
                  mismatches++;
               end
               if (rsp_data.bearing !== e.bearing) begin
                  $display("%0t: bearing expected %0d actual %0d",
                           $time, e.bearing, rsp_data.bearing);
                  mismatches++;
               end
               if (rsp_data.target_index !== e.target_index) begin
                  $display("%0t: target_index expected %0d actual %0d",
                           $time, e.target_index, rsp_data.target_index);
                  mismatches++;
               end
               if (rsp_data.all_within !== e.all_within) begin
                  $display("%0t: all_within expected %0d actual %0d",
                           $time, e.all_within, rsp_data.all_within);
                  mismatches++;
               end
            end
         end
         if (hold_pending) begin
            hold_pending = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 35);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("waypoint_heading_steering_top test failed");
            $finish;
         end
      end
   end

   initial begin
      whs_pkg::whs_req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      for (int i = 0; i < whs_pkg::MAX_WAYPOINTS; i++) begin
         wp_x[i] = '0;
         wp_y[i] = '0;
      end
      target_slot = 0;
      last_x = '0;
      last_y = '0;
      gain_reg = 16'd1608;
      radius_reg = 16'd384;
      gps_reg = 1'b1;
      count_reg = 7'd1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].known);

      // fill the whole ring before any larger count is used
      for (int i = 0; i < whs_pkg::MAX_WAYPOINTS; i++) begin
         r = '0;
         r.req_type = whs_pkg::REQ_LOAD;
         r.wp_index = 6'(i);
         r.coord_x = cluster_coord();
         r.coord_y = cluster_coord();
         r.yaw_angle = 16'($urandom);
         send_request(r, 1'b0);
      end

      for (int p = 0; p < 10; p++) begin
         drain();
         case (p)
            0: begin
               write_reg(whs_pkg::CSR_GAIN, 16'd0); write_reg(whs_pkg::CSR_RADIUS, 16'd0);
               write_reg(whs_pkg::CSR_GPS, 16'd0); write_reg(whs_pkg::CSR_COUNT, 16'd0);
            end
            1: begin
               write_reg(whs_pkg::CSR_GAIN, 16'hFFFF); write_reg(whs_pkg::CSR_RADIUS, 16'hFFFF);
               write_reg(whs_pkg::CSR_GPS, 16'd1); write_reg(whs_pkg::CSR_COUNT, 16'd64);
            end
            2: begin
               write_reg(whs_pkg::CSR_GAIN, 16'($urandom));
               write_reg(whs_pkg::CSR_RADIUS, 16'($urandom));
               write_reg(whs_pkg::CSR_GPS, 16'd0); write_reg(whs_pkg::CSR_COUNT, 16'd127);
            end
            3: begin
               write_reg(whs_pkg::CSR_GAIN, 16'($urandom));
               write_reg(whs_pkg::CSR_RADIUS, 16'd2048);
               write_reg(whs_pkg::CSR_GPS, 16'd1);
               write_reg(whs_pkg::CSR_COUNT, 16'($urandom_range(1, 64)));
            end
            4: begin
               write_reg(whs_pkg::CSR_GAIN, 16'd1608); write_reg(whs_pkg::CSR_RADIUS, 16'hFFFF);
               write_reg(whs_pkg::CSR_GPS, 16'd0); write_reg(whs_pkg::CSR_COUNT, 16'd1);
            end
            default: begin
               write_reg(whs_pkg::CSR_GAIN, (p == 6) ? 16'd1 : 16'($urandom));
               write_reg(whs_pkg::CSR_RADIUS, 16'($urandom_range(0, 8192)));
               write_reg(whs_pkg::CSR_GPS, 16'($urandom_range(1)));
               write_reg(whs_pkg::CSR_COUNT, 16'($urandom_range(1, 64)));
            end
         endcase
         no_idle = (p == 5);
         if (p == 6) hold_pending = 1;
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_request(random_request(), 1'b0);
      end
      no_idle = 0;
      req_valid <= 1'b0;

      while (expected_steering_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("waypoint_heading_steering_top test passed");
      else
         $display("waypoint_heading_steering_top test failed");
      $finish;
   end

endmodule
`default_nettype wire
